// ===== rtl/core/swtb_pkg.sv =====
package swtb_pkg;
  localparam int StoreDepthDefault = 4096;
  localparam logic [7:0] NewlineByte = 8'h0A;
  localparam logic [7:0] WrapColumnsReset = 8'd80;
  localparam logic [2:0] OpInsert = 3'd0;
  localparam logic [2:0] OpRemove = 3'd1;
  localparam logic [2:0] OpLineStart = 3'd2;
  localparam logic [2:0] OpLineLength = 3'd3;
  localparam logic [2:0] OpLineCount = 3'd4;
  localparam int OpWidth = 3;
  localparam int PosWidth = 12;
  localparam int ByteWidth = 8;
  localparam int AnswerWidth = 13;
endpackage

// ===== rtl/core/swtb_if.sv =====
interface swtb_in_if;
  import swtb_pkg::*;
  logic valid;
  logic ready;
  logic [OpWidth-1:0] op;
  logic [PosWidth-1:0] position;
  logic [ByteWidth-1:0] char_byte;
  logic [PosWidth-1:0] line_number;
  modport source(output valid, op, position, char_byte, line_number, input ready);
  modport sink(input valid, op, position, char_byte, line_number, output ready);
endinterface

interface swtb_out_if;
  import swtb_pkg::*;
  logic valid;
  logic ready;
  logic status;
  logic [AnswerWidth-1:0] answer;
  logic [AnswerWidth-1:0] fill_count;
  modport source(output valid, status, answer, fill_count, input ready);
  modport sink(input valid, status, answer, fill_count, output ready);
endinterface

interface swtb_cfg_if;
  logic valid;
  logic ready;
  logic [7:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

// ===== rtl/core/swtb_ram.sv =====
module swtb_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// ===== rtl/core/soft_wrapped_text_buffer.sv =====
// Soft-wrapped text buffer.
// Channel in_ch carries one command word: op, position, char_byte and
// line_number. Channel out_ch returns one result word per command: status,
// answer and fill_count. Channel cfg_ch writes wrap_columns (reset 80); write
// it only while no command is in flight.
// The text sits in a single-port-read, single-port-write RAM of StoreDepth
// bytes. Every valid operation walks the RAM one character at a time: an
// insert or remove moves each later character by one place, a query walks
// from position zero, and at most the fill count of characters are moved or
// walked. A byte is read in the cycle before it can be used. The line length
// query also walks the line itself. Rejected and unknown commands walk
// nothing and go straight to the done state.
// One command is handled at a time; in_ch.ready is high only when the engine
// is idle and the result register is free or being emptied.
// The result stays in an output register until out_ch accepts it; while the
// receiver stalls, no new command is taken.
// Reset clears the fill count and wrap_columns to 80; the RAM needs no
// clearing since only positions below the fill count are ever used.
module soft_wrapped_text_buffer #(
  parameter int StoreDepth = swtb_pkg::StoreDepthDefault
) (
  input logic clk,
  input logic rst,
  swtb_in_if.sink    in_ch,
  swtb_out_if.source out_ch,
  swtb_cfg_if.sink   cfg_ch
);
  import swtb_pkg::*;

  localparam int AddrWidth = $clog2(StoreDepth);
  localparam int CntWidth = AddrWidth + 1;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StIns = 3'd1;
  localparam logic [2:0] StRem = 3'd2;
  localparam logic [2:0] StWalk = 3'd3;
  localparam logic [2:0] StLen = 3'd4;
  localparam logic [2:0] StDone = 3'd5;

  logic [2:0] state;
  logic [7:0] wrap_columns;
  logic [CntWidth-1:0] char_count;
  logic [OpWidth-1:0] op;
  logic [CntWidth-1:0] pos;
  logic [ByteWidth-1:0] byte_in;
  logic [PosWidth-1:0] target;
  // idx: walk index; rd_ok: rd_data holds idx (ins: idx-1, rem: idx+1).
  logic [CntWidth-1:0] idx;
  logic [CntWidth-1:0] lines;
  // col is as wide as the fill count, since without soft wrap a line can
  // run over the whole store.
  logic [CntWidth-1:0] col;
  logic [CntWidth-1:0] len;
  logic rd_ok;
  logic status;
  logic [CntWidth-1:0] answer;

  logic wr_en;
  logic [AddrWidth-1:0] wr_addr, rd_addr;
  logic [7:0] wr_data, rd_data;

  swtb_ram #(.Width(8), .Depth(StoreDepth)) u_ram (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  logic take;
  assign in_ch.ready = (state == StIdle) && (!out_ch.valid || out_ch.ready);
  assign take = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  logic ends;
  logic [CntWidth-1:0] col_inc;
  assign col_inc = col + CntWidth'(1);
  assign ends = (rd_data == NewlineByte) ||
                (wrap_columns != 8'd0 && col_inc == CntWidth'(wrap_columns));

  logic [CntWidth-1:0] limit;
  assign limit = (wrap_columns == 8'd0) ? CntWidth'(StoreDepth)
                                        : CntWidth'(wrap_columns - 8'd1);

  always_comb begin
    wr_en = 1'b0;
    wr_addr = idx[AddrWidth-1:0];
    wr_data = rd_data;
    rd_addr = idx[AddrWidth-1:0];
    case (state)
      StIns: begin
        // Read idx-1 ahead; write the byte fetched last cycle to idx.
        rd_addr = AddrWidth'(idx - CntWidth'(1));
        if (idx == pos) begin
          // The gap has reached pos, so the new byte goes in.
          wr_en = 1'b1;
          wr_addr = AddrWidth'(idx);
          wr_data = byte_in;
        end else if (rd_ok) begin
          wr_en = 1'b1;
          wr_addr = AddrWidth'(idx);
        end
      end
      StRem: begin
        rd_addr = AddrWidth'(idx + CntWidth'(1));
        if (rd_ok) begin
          wr_en = 1'b1;
          wr_addr = AddrWidth'(idx);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      char_count <= '0;
      wrap_columns <= WrapColumnsReset;
      out_ch.valid <= 1'b0;
      rd_ok <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        wrap_columns <= cfg_ch.data;
      end
      if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      case (state)
        StIdle: begin
          rd_ok <= 1'b0;
          if (take) begin
            op <= in_ch.op;
            pos <= CntWidth'(in_ch.position);
            byte_in <= in_ch.char_byte;
            target <= in_ch.line_number;
            lines <= '0;
            col <= '0;
            len <= '0;
            status <= 1'b0;
            answer <= '0;
            case (in_ch.op)
              OpInsert: begin
                if ((CntWidth'(in_ch.position) >= CntWidth'(StoreDepth))
                    || (char_count >= CntWidth'(StoreDepth))
                    || (CntWidth'(in_ch.position) > char_count)) begin
                  status <= 1'b1;
                  state <= StDone;
                end else begin
                  idx <= char_count;
                  state <= StIns;
                end
              end
              OpRemove: begin
                if (CntWidth'(in_ch.position) >= char_count) begin
                  status <= 1'b1;
                  state <= StDone;
                end else begin
                  idx <= CntWidth'(in_ch.position);
                  state <= StRem;
                end
              end
              OpLineStart, OpLineLength, OpLineCount: begin
                idx <= '0;
                state <= StWalk;
              end
              default: begin
                status <= 1'b1;
                state <= StDone;
              end
            endcase
          end
        end
        StIns: begin
          // Moving down from char_count to pos; when idx == pos write byte.
          if (idx == pos) begin
            state <= StDone;
            char_count <= char_count + CntWidth'(1);
            rd_ok <= 1'b0;
          end else if (!rd_ok) begin
            rd_ok <= 1'b1;
          end else begin
            idx <= idx - CntWidth'(1);
            rd_ok <= 1'b0;
          end
        end
        StRem: begin
          if (idx + CntWidth'(1) >= char_count) begin
            char_count <= char_count - CntWidth'(1);
            state <= StDone;
            rd_ok <= 1'b0;
          end else if (!rd_ok) begin
            rd_ok <= 1'b1;
          end else begin
            idx <= idx + CntWidth'(1);
            rd_ok <= 1'b0;
          end
        end
        StWalk: begin
          if (op != OpLineCount && (idx >= char_count || lines >= CntWidth'(target))) begin
            rd_ok <= 1'b0;
            if (idx >= char_count) begin
              status <= 1'b1;
            end
            if (op == OpLineStart || idx >= char_count) begin
              answer <= (op == OpLineStart) ? idx : '0;
              state <= StDone;
            end else begin
              state <= StLen;
            end
          end else if (op == OpLineCount && idx >= char_count) begin
            answer <= (col != '0) ? lines + CntWidth'(1) : lines;
            state <= StDone;
            rd_ok <= 1'b0;
          end else if (!rd_ok) begin
            rd_ok <= 1'b1;
          end else begin
            rd_ok <= 1'b0;
            idx <= idx + CntWidth'(1);
            if (ends) begin
              lines <= lines + CntWidth'(1);
              col <= '0;
            end else begin
              col <= col_inc;
            end
          end
        end
        StLen: begin
          if (len >= limit || idx >= char_count) begin
            answer <= len;
            state <= StDone;
            rd_ok <= 1'b0;
          end else if (!rd_ok) begin
            rd_ok <= 1'b1;
          end else begin
            rd_ok <= 1'b0;
            if (rd_data == NewlineByte) begin
              answer <= len;
              state <= StDone;
            end else begin
              len <= len + CntWidth'(1);
              idx <= idx + CntWidth'(1);
            end
          end
        end
        StDone: begin
          out_ch.valid <= 1'b1;
          out_ch.status <= status;
          out_ch.answer <= AnswerWidth'(answer);
          out_ch.fill_count <= AnswerWidth'(char_count);
          state <= StIdle;
        end
        default: state <= StIdle;
      endcase
    end
  end

endmodule
